/* rtl/core/sofd_pkg.sv */
// ----------------------------------------------------------------------------
// sofd_pkg
// Shared constants, types and helpers for the start/end delimited deframer.
// ----------------------------------------------------------------------------
package sofd_pkg;

    localparam int FRAME_BYTES = 22;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

    localparam int WORD_COUNT  = 5;
    localparam int WORD_W      = 32;
    localparam int WORD_FIRST  = 1;
    localparam int WORD_LAST   = 20;
    localparam int IDX_W       = $clog2(WORD_LAST + 1);
    localparam int WORD_SEL_W  = $clog2(WORD_COUNT);

    localparam int TICK_W      = 17;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  START_RESET   = 8'd165;
    localparam logic [7:0]  END_RESET     = 8'd90;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE,
        REG_END_BYTE,
        REG_TIMEOUT_TICKS
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  end_byte;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                             frame_done;
        logic                             online;
        logic [WORD_COUNT-1:0][WORD_W-1:0] words;
    } result_t;

    // Ring address: base plus offset, both below FRAME_BYTES.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offs);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (ADDR_W + 1)'(FRAME_BYTES))
        begin
            sum = sum - (ADDR_W + 1)'(FRAME_BYTES);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/core/sofd_in_if.sv */
// ----------------------------------------------------------------------------
// sofd_in_if
// Input channel: one link byte or one millisecond tick per beat.
// ----------------------------------------------------------------------------
interface sofd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

/* rtl/core/sofd_out_if.sv */
// ----------------------------------------------------------------------------
// sofd_out_if
// Result channel: frame status and the five words of the last good frame.
// ----------------------------------------------------------------------------
interface sofd_out_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic        online;
    logic [31:0] word_pitch;
    logic [31:0] word_yaw;
    logic [31:0] word_pitch_rate;
    logic [31:0] word_yaw_rate;
    logic [31:0] word_stamp;

    modport source (output valid, output frame_done, output online, output word_pitch,
                    output word_yaw, output word_pitch_rate, output word_yaw_rate,
                    output word_stamp, input ready);
    modport sink   (input valid, input frame_done, input online, input word_pitch,
                    input word_yaw, input word_pitch_rate, input word_yaw_rate,
                    input word_stamp, output ready);
endinterface

/* rtl/core/sofd_cfg_if.sv */
// ----------------------------------------------------------------------------
// sofd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sofd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sofd_pkg::CFG_IDX_W-1:0]  index;
    logic [sofd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sof_eof_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// sof_eof_frame_deframer_top
// Start/end delimited fixed-length frame deframer with link-online tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per link byte (kind 0) or millisecond tick (kind 1).
//   out_ch : one beat per input beat: frame_done, online and the five words
//            of the last good frame (zero until the first one).
//   cfg_ch : register writes (start byte, end byte, timeout); always ready,
//            write only while no item is in flight.
// Timing: bytes sit in a ring buffer RAM with registered read data, and a
//   sequencer reads its entries one at a time (S_RD, then S_CMP). A tick
//   goes from accept straight to S_DONE; a byte leaving a short buffer that
//   opens with the start byte passes S_RD, S_CMP and S_CHK. A search reads
//   skipped bytes in turn, the end check reads the last frame byte, and a
//   good frame unpacks payload byte by byte (S_WRD, S_CAP). A bad end byte
//   drops one byte and restarts the search. One item is in work at a time;
//   in_ch is ready again once its result has moved into the output register.
// Reset: configuration returns to defaults, the buffer empties, the words
//   read zero and online is low. The RAM itself needs no clearing.
// Stall: the output register holds its beat while out_ch.ready is low; the
//   next item may be accepted and worked on, and waits at its end.
// ----------------------------------------------------------------------------
module sof_eof_frame_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    sofd_in_if.sink     in_ch,
    sofd_out_if.source  out_ch,
    sofd_cfg_if.sink    cfg_ch
);

    sofd_pkg::cfg_t    cfg;
    sofd_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;

    logic              out_valid_reg, out_valid_next;
    sofd_pkg::result_t out_res_reg;

    sofd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg_ch),
        .cfg   (cfg)
    );

    sofd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output slot frees up when empty or being taken this cycle
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.frame_done      = out_res_reg.frame_done;
    assign out_ch.online          = out_res_reg.online;
    assign out_ch.word_pitch      = out_res_reg.words[0];
    assign out_ch.word_yaw        = out_res_reg.words[1];
    assign out_ch.word_pitch_rate = out_res_reg.words[2];
    assign out_ch.word_yaw_rate   = out_res_reg.words[3];
    assign out_ch.word_stamp      = out_res_reg.words[4];

endmodule

/* rtl/core/sofd_ram.sv */
// ----------------------------------------------------------------------------
// sofd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sofd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 22,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sofd_cfg.sv */
// ----------------------------------------------------------------------------
// sofd_cfg
// Configuration register file: start byte, end byte and online timeout.
// ----------------------------------------------------------------------------
module sofd_cfg (
    input  logic            clk,
    input  logic            rst_n,
    sofd_cfg_if.sink        wr,
    output sofd_pkg::cfg_t  cfg
);

    sofd_pkg::cfg_t cfg_reg;
    sofd_pkg::cfg_t cfg_next;

    assign wr.ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr.valid)
        begin
            unique case (sofd_pkg::reg_index_t'(wr.index))
                sofd_pkg::REG_START_BYTE:    cfg_next.start_byte    = wr.data[7:0];
                sofd_pkg::REG_END_BYTE:      cfg_next.end_byte      = wr.data[7:0];
                sofd_pkg::REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = wr.data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte    <= sofd_pkg::START_RESET;
            cfg_reg.end_byte      <= sofd_pkg::END_RESET;
            cfg_reg.timeout_ticks <= sofd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/sofd_ctrl.sv */
// ----------------------------------------------------------------------------
// sofd_ctrl
// Frame sequencer around a ring buffer RAM: append, search, check, unpack.
// ----------------------------------------------------------------------------
module sofd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  sofd_pkg::cfg_t      cfg,
    sofd_in_if.sink             in_ch,
    output logic                res_valid,
    input  logic                res_ready,
    output sofd_pkg::result_t   res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_CHK,
        S_END,
        S_WRD,
        S_CAP,
        S_DONE
    } state_t;

    state_t                                            state_reg, state_next;
    logic [sofd_pkg::ADDR_W-1:0]                        head_reg, head_next;
    logic [sofd_pkg::LEN_W-1:0]                         len_reg, len_next;
    logic [sofd_pkg::ADDR_W-1:0]                        pos_reg, pos_next;
    logic [sofd_pkg::IDX_W-1:0]                         idx_reg, idx_next;
    logic                                              done_reg, done_next;
    logic                                              seen_reg, seen_next;
    logic [sofd_pkg::TICK_W-1:0]                        elapsed_reg, elapsed_next;
    logic [sofd_pkg::WORD_COUNT-1:0][sofd_pkg::WORD_W-1:0] words_reg, words_next;

    logic                        ram_we;
    logic [sofd_pkg::ADDR_W-1:0] ram_waddr;
    logic [sofd_pkg::ADDR_W-1:0] ram_raddr;
    logic [7:0]                  ram_rdata;

    logic [sofd_pkg::IDX_W-1:0]      idx_m1;
    logic [sofd_pkg::WORD_SEL_W-1:0] word_sel;
    logic [1:0]                      byte_sel;
    logic                            idx_in_frame;
    logic [7:0]                      cap_byte;

    sofd_ram #(
        .WIDTH (8),
        .DEPTH (sofd_pkg::FRAME_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ch.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);

    assign res.frame_done = done_reg;
    assign res.online     = seen_reg && (elapsed_reg <= {1'b0, cfg.timeout_ticks});
    assign res.words      = words_reg;

    assign idx_m1       = idx_reg - sofd_pkg::IDX_W'(sofd_pkg::WORD_FIRST);
    assign word_sel     = sofd_pkg::WORD_SEL_W'(idx_m1 >> 2);
    assign byte_sel     = idx_m1[1:0];
    assign idx_in_frame = (int'(idx_reg) < sofd_pkg::FRAME_BYTES);
    assign cap_byte     = idx_in_frame ? ram_rdata : 8'h00;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        done_next    = done_reg;
        seen_next    = seen_reg;
        elapsed_next = elapsed_reg;
        words_next   = words_reg;
        ram_we       = 1'b0;
        ram_waddr    = sofd_pkg::wrap_add(head_reg, len_reg[sofd_pkg::ADDR_W-1:0]);
        ram_raddr    = sofd_pkg::wrap_add(head_reg, pos_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    done_next = 1'b0;
                    if (in_ch.kind)
                    begin
                        if (elapsed_reg != sofd_pkg::TICK_MAX)
                        begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // append at the tail of the ring, then search from the head
                        ram_we     = 1'b1;
                        len_next   = len_reg + 1'b1;
                        pos_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (ram_rdata == cfg.start_byte)
                begin
                    // drop everything before the start byte
                    head_next  = sofd_pkg::wrap_add(head_reg, pos_reg);
                    len_next   = len_reg - sofd_pkg::LEN_W'(pos_reg);
                    state_next = S_CHK;
                end
                else if (sofd_pkg::LEN_W'(pos_reg) + 1'b1 == len_reg)
                begin
                    len_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_CHK:
            begin
                if (len_reg != sofd_pkg::LEN_W'(sofd_pkg::FRAME_BYTES))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = sofd_pkg::wrap_add(head_reg,
                                     sofd_pkg::ADDR_W'(sofd_pkg::FRAME_BYTES - 1));
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (ram_rdata == cfg.end_byte)
                begin
                    idx_next   = sofd_pkg::IDX_W'(sofd_pkg::WORD_FIRST);
                    state_next = S_WRD;
                end
                else
                begin
                    // bad end byte: drop the start byte and search again
                    head_next  = sofd_pkg::wrap_add(head_reg, sofd_pkg::ADDR_W'(1));
                    len_next   = len_reg - 1'b1;
                    pos_next   = '0;
                    state_next = S_RD;
                end
            end
            S_WRD:
            begin
                ram_raddr  = sofd_pkg::wrap_add(head_reg, sofd_pkg::ADDR_W'(idx_reg));
                state_next = S_CAP;
            end
            S_CAP:
            begin
                words_next[word_sel][{byte_sel, 3'b000} +: 8] = cap_byte;
                if (idx_reg == sofd_pkg::IDX_W'(sofd_pkg::WORD_LAST))
                begin
                    seen_next    = 1'b1;
                    elapsed_next = '0;
                    len_next     = '0;
                    done_next    = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
            seen_reg    <= 1'b0;
            elapsed_reg <= '0;
            words_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            done_reg    <= done_next;
            seen_reg    <= seen_next;
            elapsed_reg <= elapsed_next;
            words_reg   <= words_next;
        end
    end

endmodule

/* rtl/core/sofd_checker.sv */
// ----------------------------------------------------------------------------
// sofd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sofd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        frame_done,
    input logic        online,
    input logic [31:0] word_pitch,
    input logic [31:0] word_stamp
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(frame_done) && $stable(online)
             && $stable(word_pitch) && $stable(word_stamp)))
        else $error("stalled result beat changed");

    // one item in work at a time: input closes right after a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted beat");

    // a frame just taken restarts the tick count, so the link is online
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> online)
        else $error("frame done without online");

endmodule

bind sof_eof_frame_deframer_top sofd_checker u_sofd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .frame_done (out_ch.frame_done),
    .online     (out_ch.online),
    .word_pitch (out_ch.word_pitch),
    .word_stamp (out_ch.word_stamp)
);

/* tb/sofd_checker.sv */
// ----------------------------------------------------------------------------
// sofd_scoreboard
// Watches the deframer's channels and tracks its registers, buffer, tick
// counter and last frame words. Predicts one report per accepted input beat
// and compares each output beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module sofd_scoreboard (
    input  logic clk,
    input  logic rst_n,
    sofd_in_if   in_ch,
    sofd_out_if  out_ch,
    sofd_cfg_if  cfg_ch,
    output int   mismatches,
    output int   reports_due,
    output int   frames_taken,
    output int   reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]                                            start_byte_q;
    logic [7:0]                                            end_byte_q;
    logic [15:0]                                           timeout_q;
    logic [7:0]                                            held_bytes[$];
    logic                                                  seen_q;
    logic [sofd_pkg::TICK_W-1:0]                           ticks_q;
    logic [sofd_pkg::WORD_COUNT-1:0][sofd_pkg::WORD_W-1:0] words_q;
    sofd_pkg::result_t                                     frame_reports[$];

    string field_names[7] = '{"frame_done", "online", "word_pitch", "word_yaw",
                              "word_pitch_rate", "word_yaw_rate", "word_stamp"};

    // Push one byte through the start search and end check; 1 on a good frame.
    function automatic bit absorb_byte(input logic [7:0] b);
        logic [7:0] work[$];
        int         pos;
        int         w;
        int         k;
        bit         done;
        work = held_bytes;
        work.push_back(b);
        done = 1'b0;
        while (work.size() > 0)
        begin
            pos = 0;
            while (pos < work.size() && work[pos] != start_byte_q)
            begin
                pos++;
            end
            if (pos == work.size())
            begin
                work.delete();
                break;
            end
            repeat (pos) void'(work.pop_front());
            if (work.size() < sofd_pkg::FRAME_BYTES)
            begin
                break;
            end
            if (work[sofd_pkg::FRAME_BYTES-1] == end_byte_q)
            begin
                for (w = 0; w < sofd_pkg::WORD_COUNT; w++)
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        words_q[w][8*k +: 8] = work[sofd_pkg::WORD_FIRST + 4*w + k];
                    end
                end
                seen_q  = 1'b1;
                ticks_q = '0;
                done    = 1'b1;
                work.delete();
            end
            else
            begin
                // bad end byte: drop the opening byte and search again
                void'(work.pop_front());
            end
        end
        held_bytes = work;
        return done;
    endfunction

    function automatic sofd_pkg::result_t deframe_item(input logic kind,
                                                       input logic [7:0] b);
        sofd_pkg::result_t r;
        r.frame_done = 1'b0;
        if (kind)
        begin
            if (ticks_q != sofd_pkg::TICK_MAX)
            begin
                ticks_q = ticks_q + 1'b1;
            end
        end
        else
        begin
            r.frame_done = absorb_byte(b);
        end
        r.online = seen_q && (ticks_q <= {1'b0, timeout_q});
        r.words  = words_q;
        return r;
    endfunction

    function automatic void compare_report(input sofd_pkg::result_t want);
        logic [31:0] want_f[7];
        logic [31:0] got_f[7];
        int          i;
        want_f[0] = 32'(want.frame_done);
        want_f[1] = 32'(want.online);
        for (i = 0; i < sofd_pkg::WORD_COUNT; i++)
        begin
            want_f[2+i] = want.words[i];
        end
        got_f = '{32'(out_ch.frame_done), 32'(out_ch.online), out_ch.word_pitch,
                  out_ch.word_yaw, out_ch.word_pitch_rate, out_ch.word_yaw_rate,
                  out_ch.word_stamp};
        for (i = 0; i < 7; i++)
        begin
            if (got_f[i] !== want_f[i])
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %h, got %h",
                         $time, field_names[i], want_f[i], got_f[i]);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_q    = sofd_pkg::START_RESET;
            end_byte_q      = sofd_pkg::END_RESET;
            timeout_q       = sofd_pkg::TIMEOUT_RESET;
            seen_q          = 1'b0;
            ticks_q         = '0;
            words_q         = '0;
            held_bytes.delete();
            frame_reports.delete();
            mismatches      = 0;
            frames_taken    = 0;
            reports_checked = 0;
            reports_due     = 0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (sofd_pkg::reg_index_t'(cfg_ch.index))
                    sofd_pkg::REG_START_BYTE:    start_byte_q = cfg_ch.data[7:0];
                    sofd_pkg::REG_END_BYTE:      end_byte_q   = cfg_ch.data[7:0];
                    sofd_pkg::REG_TIMEOUT_TICKS: timeout_q    = cfg_ch.data;
                    default:                     ;
                endcase
            end
            // drain before fill: a beat accepted now cannot be shown this edge
            if (out_ch.valid && out_ch.ready)
            begin
                reports_checked++;
                if (frame_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat: expected none, got frame_done %b",
                             $time, out_ch.frame_done);
                end
                else
                begin
                    compare_report(frame_reports.pop_front());
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                frame_reports.push_back(deframe_item(in_ch.kind, in_ch.data_byte));
                if (frame_reports[$].frame_done)
                begin
                    frames_taken++;
                end
            end
            reports_due = frame_reports.size();
        end
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the start/end delimited deframer: directed frames, register
// changes mid-frame, random well-formed and broken frames with ticks and
// noise, a long output hold-off and a tick run past the online timeout.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int ITEM_TARGET  = 1500;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int TICK_TIMEOUT = 30;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sofd_in_if  in_ch ();
    sofd_out_if out_ch ();
    sofd_cfg_if cfg_ch ();

    int mismatches;
    int results_due;
    int frames_taken;
    int results_checked;

    logic [7:0] cur_start = sofd_pkg::START_RESET;
    logic [7:0] cur_end   = sofd_pkg::END_RESET;
    int  items_sent   = 0;
    int  burst_left   = 0;
    int  settings_used = 1;
    bit  steady       = 1'b0;
    bit  hold_req     = 1'b0;
    bit  hold_taken   = 1'b0;
    int  quiet_cycles = 0;

    always #2 clk = ~clk;

    sof_eof_frame_deframer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    sofd_scoreboard chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_ch          (cfg_ch),
        .mismatches      (mismatches),
        .reports_due     (results_due),
        .frames_taken    (frames_taken),
        .reports_checked (results_checked)
    );

    // Send one beat; gaps fall between bursts unless the run is steady.
    task automatic send_item(input logic kind, input logic [7:0] b);
        int gap;
        if (!steady && burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (results_due != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] e, input logic [15:0] t);
        sofd_pkg::reg_index_t idx[3];
        logic [15:0]          val[3];
        int                   i;
        drain_results();
        idx = '{sofd_pkg::REG_START_BYTE, sofd_pkg::REG_END_BYTE,
                sofd_pkg::REG_TIMEOUT_TICKS};
        val = '{{8'($urandom), s}, {8'($urandom), e}, t};
        for (i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge clk);
            while (!cfg_ch.ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_start = s;
        cur_end   = e;
        settings_used++;
    endtask

    task automatic send_frame(input logic [7:0] payload[20], input logic [7:0] closing);
        int i;
        send_item(1'b0, cur_start);
        for (i = 0; i < 20; i++)
        begin
            send_item(1'b0, payload[i]);
        end
        send_item(1'b0, closing);
    endtask

    // Mostly complete frames; some cut short, some with a bad end byte,
    // payload sprinkled with start and end bytes and interleaved ticks.
    task automatic send_random_frame();
        int         last;
        int         i;
        int         roll;
        logic [7:0] b;
        last = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sofd_pkg::FRAME_BYTES - 2)
                                           : sofd_pkg::FRAME_BYTES - 1;
        send_item(1'b0, cur_start);
        for (i = 1; i <= last; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_item(1'b1, 8'($urandom));
            end
            roll = $urandom_range(0, 99);
            if (i == sofd_pkg::FRAME_BYTES - 1)
            begin
                b = (roll < 85) ? cur_end : 8'($urandom);
            end
            else if (roll < 6)
            begin
                b = cur_start;
            end
            else if (roll < 9)
            begin
                b = cur_end;
            end
            else
            begin
                b = 8'($urandom);
            end
            send_item(1'b0, b);
        end
    endtask

    task automatic send_random_unit();
        int pick;
        int n;
        int i;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
        begin
            send_random_frame();
        end
        else if (pick == 7)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                send_item(1'b0, 8'($urandom));
            end
        end
        else if (pick == 8)
        begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++)
            begin
                send_item(1'b1, 8'($urandom));
            end
        end
        else
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                send_item(1'b0, cur_start);
            end
            send_random_frame();
        end
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            if (with_hold && !hold_req && items_sent > goal - count + 50)
            begin
                hold_req = 1'b1;
            end
            send_random_unit();
        end
    endtask

    // Receiver: ready pattern changes mode every so often; one long hold-off.
    initial
    begin
        int mode;
        int span;
        int beat_no;
        mode    = 0;
        span    = 0;
        beat_no = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 120);
            end
            span--;
            beat_no++;
            if (steady || mode == 0)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (mode == 1)
            begin
                out_ch.ready <= (beat_no % 4) != 0;
            end
            else if (mode == 2)
            begin
                out_ch.ready <= 1'($urandom);
            end
            else
            begin
                out_ch.ready <= (beat_no % 8) == 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results still due",
                     $time, quiet_cycles, results_due);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] edge_payload[20];
        logic [7:0] rand_payload[20];
        int         i;
        int         share;

        in_ch.valid     = 1'b0;
        in_ch.kind      = 1'b0;
        in_ch.data_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = sofd_pkg::REG_START_BYTE;
        cfg_ch.data     = 16'h0000;
        edge_payload = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h5A, 8'hA5,
                         8'h12, 8'h34, 8'h56, 8'h78};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // No frame yet: tick, noise, then a good frame with extreme payload
        // (embedded start and end values inside), then a tick.
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_frame(edge_payload, cur_end);
        send_item(1'b1, 8'h00);

        // Zero timeout: a single tick after a frame takes the link offline.
        set_config(8'h00, 8'hFF, 16'd0);
        for (i = 0; i < 20; i++)
        begin
            rand_payload[i] = 8'($urandom);
        end
        send_frame(rand_payload, cur_end);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h12);

        // Start byte changed while a partial frame sits in the buffer.
        send_item(1'b0, cur_start);
        send_item(1'b0, 8'h11);
        send_item(1'b0, 8'h33);
        send_item(1'b0, 8'h44);
        set_config(8'h33, 8'hFF, 16'd5);
        for (i = 0; i < 19; i++)
        begin
            send_item(1'b0, 8'($urandom));
        end
        send_item(1'b0, cur_end);

        share = ITEM_TARGET / 4;
        set_config(8'hFF, 8'h00, 16'hFFFF);
        run_random(share, 1'b1);
        set_config(8'($urandom), 8'($urandom), 16'($urandom_range(0, 300)));
        run_random(share, 1'b0);
        set_config(8'($urandom), 8'($urandom), 16'd0);
        run_random(share / 2, 1'b0);
        set_config(sofd_pkg::START_RESET, sofd_pkg::END_RESET, sofd_pkg::TIMEOUT_RESET);
        run_random(share, 1'b0);

        // Tick run with a short timeout: online holds up to the timeout,
        // then drops and stays low.
        set_config(sofd_pkg::START_RESET, sofd_pkg::END_RESET, 16'(TICK_TIMEOUT));
        for (i = 0; i < 20; i++)
        begin
            rand_payload[i] = 8'($urandom);
        end
        send_frame(rand_payload, cur_end);
        drain_results();
        steady = 1'b1;
        for (i = 0; i < TICK_TIMEOUT + 10; i++)
        begin
            send_item(1'b1, 8'($urandom));
        end
        send_item(1'b0, 8'h3C);
        steady = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d input beats under %0d register settings; %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("%0d good frames, a long output hold-off and a tick run past timeout seen.",
                 frames_taken);
        if (mismatches == 0 && results_due == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
